// ----- rtl/core/neighbor_pdr_link_estimator_core_assert.svh -----
// Assertion macros for the neighbour PDR link estimator core.
// Depends on nothing; taken in by the top level with an include.
`ifndef NEIGHBOR_PDR_LINK_ESTIMATOR_CORE_ASSERT_SVH
`define NEIGHBOR_PDR_LINK_ESTIMATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npdr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NPDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npdr assertion failed");

`endif

// ----- rtl/core/npdr_pkg.sv -----
// Shared types and constants of the neighbour PDR link estimator.
// Used by the controller, the datapath and the top level; depends on nothing.
package npdr_pkg;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_PACKET = 2'd2;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_COUNTED    = 3'd0;
  localparam logic [2:0] ST_UPDATED    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN    = 3'd2;
  localparam logic [2:0] ST_STALE      = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_TABLE_DONE = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] WINDOW_RESET = 16'd100;
  localparam logic [8:0]  ALPHA_RESET  = 9'd128;
  localparam logic [8:0]  ALPHA_ONE    = 9'd256;

  // Percent arithmetic.
  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam logic [15:0] CNT_SAT   = 16'hFFFF;
  localparam int          DVD_W     = 23;
  localparam int          DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd23;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] sender_addr;
    logic [7:0]  link_id;
    logic [15:0] sequence_number;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] entry_index;
    logic [7:0] link_out;
    logic [6:0] pdr_value;
    logic       pdr_valid;
    logic [6:0] pdr_sample_out;
  } out_item_t;

  // One neighbour table entry as held in the table memory.
  typedef struct packed {
    logic [15:0] sender;
    logic [7:0]  link;
    logic [15:0] last_seq;
    logic [16:0] next_upd;
    logic [15:0] recv;
    logic [15:0] sent;
    logic [6:0]  smooth;
    logic [6:0]  sample;
    logic        known;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       item_load;
    logic       ent_new;
    logic       scan_rst;
    logic       scan_issue;
    logic       ent_load;
    logic       ent_count;
    logic       div_start;
    logic       div_step;
    logic       blend;
    logic       wr_en;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       res_load;
    logic       res_entry;
    logic [2:0] res_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       hit;
    logic       cmp_vld;
    logic       scan_more;
    logic       stale;
    logic       due;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/npdr_ctrl.sv -----
// Controller state machine of the neighbour PDR link estimator.
// Depends on npdr_pkg; drives the datapath through ctrl_cmd_t only.
module npdr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  npdr_pkg::dp_status_t  st,
  output npdr_pkg::ctrl_cmd_t   cmd
);
  import npdr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SEARCH   = 4'd2;
  localparam logic [3:0] S_CHECK    = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_DIV      = 4'd5;
  localparam logic [3:0] S_BLEND    = 4'd6;
  localparam logic [3:0] S_WRITE    = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [2:0] code_r, code_nxt;
  logic       res_entry_r, res_entry_nxt;

  // Only one transaction is in the block at a time.
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    res_entry_nxt = res_entry_r;
    cmd           = '0;
    cmd.res_status = code_r;
    cmd.res_entry  = res_entry_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.command)
          CMD_ADD: begin
            if (st.full) begin
              code_nxt      = ST_TABLE_FULL;
              res_entry_nxt = 1'b0;
              state_nxt     = S_FINISH;
            end else begin
              cmd.ent_new   = 1'b1;
              code_nxt      = ST_TABLE_DONE;
              res_entry_nxt = 1'b1;
              state_nxt     = S_WRITE;
            end
          end
          CMD_CLEAR: begin
            cmd.cnt_clr   = 1'b1;
            code_nxt      = ST_TABLE_DONE;
            res_entry_nxt = 1'b0;
            state_nxt     = S_FINISH;
          end
          CMD_PACKET: begin
            cmd.scan_rst = 1'b1;
            state_nxt    = S_SEARCH;
          end
          default: begin
            code_nxt      = ST_TABLE_DONE;
            res_entry_nxt = 1'b0;
            state_nxt     = S_FINISH;
          end
        endcase
      end
      S_SEARCH: begin
        // One table read is issued per cycle; the compare uses the registered read data.
        if (st.hit) begin
          cmd.ent_load = 1'b1;
          state_nxt    = S_CHECK;
        end else if (st.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else if (!st.cmp_vld) begin
          code_nxt      = ST_UNKNOWN;
          res_entry_nxt = 1'b0;
          state_nxt     = S_FINISH;
        end
      end
      S_CHECK: begin
        res_entry_nxt = 1'b1;
        if (st.stale) begin
          code_nxt  = ST_STALE;
          state_nxt = S_FINISH;
        end else begin
          cmd.ent_count = 1'b1;
          if (st.due) begin
            code_nxt  = ST_UPDATED;
            state_nxt = S_MUL;
          end else begin
            code_nxt  = ST_COUNTED;
            state_nxt = S_WRITE;
          end
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_BLEND;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_BLEND: begin
        cmd.blend = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.cnt_inc = (st.command == CMD_ADD);
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        // Wait until the output register can take the result.
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ST_TABLE_DONE;
      res_entry_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      res_entry_r <= res_entry_nxt;
    end
  end

endmodule

// ----- rtl/core/npdr_dp.sv -----
// Datapath of the neighbour PDR link estimator: table memory, search,
// counters, percent divider, smoothing and the output register. Uses npdr_pkg.
module npdr_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  npdr_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [npdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [npdr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  npdr_pkg::ctrl_cmd_t                 cmd,
  output npdr_pkg::dp_status_t                st,
  output npdr_pkg::out_item_t                 out_item,
  output logic                                out_valid,
  input  logic                                out_stall
);
  import npdr_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Table memory, one whole entry per word.
  entry_t table_mem [TABLE_DEPTH];

  logic [15:0]          window_r;
  logic [8:0]           alpha_r;
  in_item_t             item_r;
  logic [CW-1:0]        entry_count_r;
  logic [CW-1:0]        scan_idx_r;
  logic                 cmp_vld_r;
  logic [IW-1:0]        cmp_idx_r;
  entry_t               rd_q_r;
  entry_t               ent_r, ent_nxt;
  logic [IW-1:0]        ent_idx_r;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [15:0]          dvs_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  out_item_t            out_item_r, out_item_nxt;
  logic                 out_valid_r;

  logic [15:0] gap;
  logic [16:0] sent_sum;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [6:0]  smp;
  logic [8:0]  alpha_eff;
  logic [17:0] mix_sum;
  logic [9:0]  mix;
  logic [6:0]  blended;

  // Status towards the controller.
  always_comb begin
    st.command   = item_r.command;
    st.full      = (entry_count_r >= CW'(TABLE_DEPTH));
    st.hit       = cmp_vld_r && (rd_q_r.sender == item_r.sender_addr);
    st.cmp_vld   = cmp_vld_r;
    st.scan_more = (scan_idx_r < entry_count_r);
    st.stale     = (item_r.sequence_number <= ent_r.last_seq);
    st.due       = ({1'b0, item_r.sequence_number} >= ent_r.next_upd);
    st.div_done  = (div_cnt_r == '0);
    st.out_free  = !out_valid_r || !out_stall;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      alpha_r  <= ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: window_r <= cfg_wdata;
        CFG_ALPHA:  alpha_r  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Captured input transaction.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_item;
    end
  end

  // Table fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cmd.cnt_clr) begin
      entry_count_r <= '0;
    end else if (cmd.cnt_inc) begin
      entry_count_r <= entry_count_r + 1'b1;
    end
  end

  // Sequential search: the read of one entry overlaps the compare of the last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else if (cmd.scan_rst) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_issue;
      if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_q_r    <= table_mem[scan_idx_r[IW-1:0]];
      cmp_idx_r <= scan_idx_r[IW-1:0];
    end
    if (cmd.wr_en) begin
      table_mem[ent_idx_r] <= ent_r;
    end
  end

  // Counter update and smoothing arithmetic.
  always_comb begin
    gap      = item_r.sequence_number - ent_r.last_seq;
    sent_sum = {1'b0, ent_r.sent} + {1'b0, gap};
    smp      = (quo_r > DVD_W'(PCT_MAX)) ? PCT_MAX : quo_r[6:0];
    alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    mix_sum  = 18'(alpha_eff) * 18'(ent_r.smooth)
             + 18'(ALPHA_ONE - alpha_eff) * 18'(smp);
    mix      = mix_sum[17:8];
    if (!ent_r.known) begin
      blended = smp;
    end else if (mix > 10'(PCT_MAX)) begin
      blended = PCT_MAX;
    end else begin
      blended = mix[6:0];
    end
  end

  // Working copy of the entry being handled.
  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ent_new) begin
      ent_nxt.sender   = item_r.sender_addr;
      ent_nxt.link     = item_r.link_id;
      ent_nxt.last_seq = '0;
      ent_nxt.next_upd = {1'b0, window_r};
      ent_nxt.recv     = '0;
      ent_nxt.sent     = '0;
      ent_nxt.smooth   = '0;
      ent_nxt.sample   = '0;
      ent_nxt.known    = 1'b0;
    end else if (cmd.ent_load) begin
      ent_nxt = rd_q_r;
    end else if (cmd.ent_count) begin
      ent_nxt.sent     = sent_sum[16] ? CNT_SAT : sent_sum[15:0];
      ent_nxt.recv     = (ent_r.recv == CNT_SAT) ? CNT_SAT : ent_r.recv + 16'd1;
      ent_nxt.last_seq = item_r.sequence_number;
    end else if (cmd.blend) begin
      ent_nxt.sample   = smp;
      ent_nxt.smooth   = blended;
      ent_nxt.known    = 1'b1;
      ent_nxt.sent     = '0;
      ent_nxt.recv     = '0;
      ent_nxt.next_upd = {1'b0, item_r.sequence_number} + {1'b0, window_r};
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (cmd.ent_new) begin
      ent_idx_r <= entry_count_r[IW-1:0];
    end else if (cmd.ent_load) begin
      ent_idx_r <= cmp_idx_r;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    rem_ge  = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = rem_ge ? 16'(rem_sh - {1'b0, dvs_r}) : rem_sh[15:0];
    quo_nxt = {quo_r[DVD_W-2:0], rem_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= DIV_STEPS;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= DVD_W'(ent_r.recv) * DVD_W'(PCT_MAX);
      rem_r <= '0;
      dvs_r <= (ent_r.sent == '0) ? 16'd1 : ent_r.sent;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Result fields.
  always_comb begin
    out_item_nxt        = '0;
    out_item_nxt.status = cmd.res_status;
    if (cmd.res_entry) begin
      out_item_nxt.entry_index    = 4'(ent_idx_r);
      out_item_nxt.link_out       = ent_r.link;
      out_item_nxt.pdr_value      = ent_r.known ? ent_r.smooth : 7'd0;
      out_item_nxt.pdr_valid      = ent_r.known;
      out_item_nxt.pdr_sample_out = ent_r.sample;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/neighbor_pdr_link_estimator_core.sv -----
// Top level of the neighbour PDR estimator; uses npdr_pkg, npdr_ctrl, npdr_dp and the macros.
// Clear, unused and full-table adds go straight to the result, and an add writes a new entry.
// A packet searches the table (one table read a cycle); a stale match stops there, a fresh one
// is counted and, when due, updates the PDR through the 23-step percent divider; an unknown
// sender ends the search. One transaction is taken at a time, held back further by output
// stalls. Sync reset: empty table, window 100, weight 128.
module neighbor_pdr_link_estimator_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  npdr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output npdr_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [npdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import npdr_pkg::*;

  `include "neighbor_pdr_link_estimator_core_assert.svh"

  ctrl_cmd_t  cmd_w;
  dp_status_t st_w;

  // Controller.
  npdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st_w),
    .cmd      (cmd_w)
  );

  // Datapath.
  npdr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_w),
    .st        (st_w),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // A result never overwrites one that is still being held.
  `NPDR_ASSERT_IMPL(a_res_slot_free, clk, rst_n, cmd_w.res_load, st_w.out_free)
  // The table never grows past its depth.
  `NPDR_ASSERT_IMPL(a_no_overfill, clk, rst_n, cmd_w.cnt_inc, !st_w.full)
  // The divider is never stepped beyond its last quotient bit.
  `NPDR_ASSERT_IMPL(a_div_bounded, clk, rst_n, cmd_w.div_step, !st_w.div_done)
  // After a transaction is taken the block is busy with it.
  `NPDR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule
